>>> design/fbpb_pkg.sv
// ----------------------------------------------------------------------------
// fbpb_pkg: shared types, constants and twiddle generation
// Word types for the sample and result queues, register map, and the
// elaboration-time twiddle function used to build the twiddle ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpb_pkg;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } in_word_t;

    typedef struct packed {
        logic signed [9:0] peak_bin;
        logic              end_of_message;
    } out_word_t;

    localparam int unsigned CFG_W           = 11;
    localparam int unsigned CFG_BATCH_LEN   = 0;
    localparam logic [CFG_W-1:0] BATCH_LEN_RESET = 11'd256;
    localparam int unsigned PEAK_OFFSET     = 2;
    localparam logic [63:0] PI_Q30          = 64'd3373259426;
    localparam int unsigned TW_W            = 17;

    // Q2.30 to scale 2^15, rounded half up, negatives clamp to zero
    function automatic logic signed [TW_W-1:0] q30_to_q15(input logic signed [63:0] v);
        logic [63:0] u;
        u = (v < 0) ? 64'd0 : v;
        u = (u + 64'd16384) >> 15;
        return u[TW_W-1:0];
    endfunction

    // cos/sin on the first octant, returns {cos, sin}
    function automatic logic [2*TW_W-1:0] octant(input logic [63:0] k,
                                                 input int unsigned log2n);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic signed [63:0] ss;
        logic signed [63:0] cs;
        x  = (PI_Q30 * 64'd2 * k) >> log2n;
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1 << 30;
        ss = x;
        cs = 64'sd1 <<< 30;
        ts = ((ts * x2) >> 30) / 64'd6;   tc = ((tc * x2) >> 30) / 64'd2;
        ss = ss - ts;                     cs = cs - tc;
        ts = ((ts * x2) >> 30) / 64'd20;  tc = ((tc * x2) >> 30) / 64'd12;
        ss = ss + ts;                     cs = cs + tc;
        ts = ((ts * x2) >> 30) / 64'd42;  tc = ((tc * x2) >> 30) / 64'd30;
        ss = ss - ts;                     cs = cs - tc;
        ts = ((ts * x2) >> 30) / 64'd72;  tc = ((tc * x2) >> 30) / 64'd56;
        ss = ss + ts;                     cs = cs + tc;
        ts = ((ts * x2) >> 30) / 64'd110; tc = ((tc * x2) >> 30) / 64'd90;
        ss = ss - ts;                     cs = cs - tc;
        ts = ((ts * x2) >> 30) / 64'd156; tc = ((tc * x2) >> 30) / 64'd132;
        ss = ss + ts;                     cs = cs + tc;
        return {q30_to_q15(cs), q30_to_q15(ss)};
    endfunction

    // twiddle W^k, returns {re, im}
    function automatic logic [2*TW_W-1:0] twiddle(input int unsigned k,
                                                  input int unsigned log2n);
        int unsigned q;
        int unsigned e;
        int unsigned m;
        logic [2*TW_W-1:0] cs;
        logic signed [TW_W-1:0] c;
        logic signed [TW_W-1:0] s;
        logic signed [TW_W-1:0] t;
        q = (1 << log2n) >> 2;
        e = (1 << log2n) >> 3;
        m = (k < q) ? k : k - q;
        if (m <= e)
        begin
            cs = octant(64'(m), log2n);
            c  = cs[2*TW_W-1:TW_W];
            s  = cs[TW_W-1:0];
        end
        else
        begin
            cs = octant(64'(q - m), log2n);
            s  = cs[2*TW_W-1:TW_W];
            c  = cs[TW_W-1:0];
        end
        if (k >= q)
        begin
            t = c;
            c = -s;
            s = t;
        end
        return {c, -s};
    endfunction

endpackage

`default_nettype wire

>>> design/fbpb_fifo.sv
// ----------------------------------------------------------------------------
// fbpb_fifo: two-entry word queue
// Decouples producer and consumer; full and empty are registered-state flags.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpb_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

endmodule

`default_nettype wire

>>> design/fbpb_front.sv
// ----------------------------------------------------------------------------
// fbpb_front: sample intake
// Stores samples of the open block, closes blocks and queues block jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpb_front #(
    parameter int unsigned N_POINTS = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [fbpb_pkg::CFG_W-1:0]  batch_len,
    input  wire logic                        push,
    input  wire fbpb_pkg::in_word_t          item,
    output logic                             full,
    output logic                             job_push,
    output logic [$clog2(N_POINTS):0]        job_data,
    input  wire logic                        job_full,
    input  wire logic                        loaded,
    input  wire logic [$clog2(N_POINTS)-1:0] smp_rd_addr,
    output logic signed [15:0]               smp_rd_data
);

    localparam int unsigned LOG2N = $clog2(N_POINTS);
    localparam int unsigned CW    = LOG2N;
    localparam int unsigned WW    = (CW + 1 > fbpb_pkg::CFG_W) ? CW + 1 : fbpb_pkg::CFG_W;

    logic signed [15:0] mem_reg [N_POINTS];
    logic [CW:0]        fill_reg;
    logic               hold_reg;
    logic               accept;
    logic [CW:0]        fill_inc;
    logic [WW-1:0]      len_w;
    logic [WW-1:0]      blen;
    logic               close_blk;

    assign full   = hold_reg || job_full;
    assign accept = push && !full;
    assign fill_inc = fill_reg + 1'b1;
    assign len_w  = WW'(batch_len);

    always_comb
    begin
        priority if (len_w == '0)
        begin
            blen = WW'(1);
        end
        else if (len_w > WW'(N_POINTS))
        begin
            blen = WW'(N_POINTS);
        end
        else
        begin
            blen = len_w;
        end
    end

    assign close_blk = accept && ((WW'(fill_inc) >= blen) || item.last);
    assign job_push  = close_blk;
    assign job_data  = fill_inc;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_reg[fill_reg[CW-1:0]] <= item.sample;
        end
        smp_rd_data <= mem_reg[smp_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            hold_reg <= 1'b0;
        end
        else
        begin
            if (close_blk)
            begin
                fill_reg <= '0;
                hold_reg <= 1'b1;
            end
            else if (accept)
            begin
                fill_reg <= fill_inc;
            end
            if (loaded)
            begin
                hold_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/fbpb_back.sv
// ----------------------------------------------------------------------------
// fbpb_back: transform engine
// Loads a block bit-reversed, runs radix-2 butterflies on one shared unit,
// then scans bin magnitudes and emits the peak bin word.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpb_back #(
    parameter int unsigned N_POINTS = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [$clog2(N_POINTS)+1:0] job_data,
    input  wire logic                        job_empty,
    output logic                             job_pop,
    output logic                             loaded,
    output logic [$clog2(N_POINTS)-1:0]      smp_rd_addr,
    input  wire logic signed [15:0]          smp_rd_data,
    output logic                             res_push,
    output fbpb_pkg::out_word_t              res_word,
    input  wire logic                        res_full
);

    localparam int unsigned LOG2N = $clog2(N_POINTS);
    localparam int unsigned HALF  = N_POINTS / 2;
    localparam int unsigned HW    = LOG2N - 1;
    localparam int unsigned SW    = $clog2(LOG2N);
    localparam int unsigned TWW   = fbpb_pkg::TW_W;

    typedef logic [2*TWW-1:0] tw_word_t;
    typedef tw_word_t tw_rom_t [HALF];

    function automatic tw_rom_t build_rom();
        tw_rom_t rom;
        for (int k = 0; k < HALF; k++)
        begin
            rom[k] = fbpb_pkg::twiddle(k, LOG2N);
        end
        return rom;
    endfunction

    localparam tw_rom_t TW_ROM = build_rom();

    function automatic logic [LOG2N-1:0] bitrev(input logic [LOG2N-1:0] v);
        logic [LOG2N-1:0] r;
        for (int b = 0; b < LOG2N; b++)
        begin
            r[LOG2N-1-b] = v[b];
        end
        return r;
    endfunction

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_LOAD_END, S_BF_RD, S_BF_MUL, S_BF_SUM, S_BF_WA, S_BF_WB,
        S_MAG_RD, S_MAG_MUL, S_MAG_CMP, S_OUT
    } state_t;

    state_t               state_reg;
    logic [63:0]          work_mem [N_POINTS];
    logic [63:0]          rd_a_reg;
    logic [63:0]          rd_b_reg;
    tw_word_t             tw_reg;
    logic [LOG2N:0]       count_reg;
    logic                 last_reg;
    logic [LOG2N-1:0]     ld_cnt_reg;
    logic                 ld_v_reg;
    logic [LOG2N-1:0]     ld_idx_reg;
    logic                 ld_in_reg;
    logic [HW-1:0]        bf_reg;
    logic [SW-1:0]        stage_reg;
    logic signed [48:0]   p_rr_reg;
    logic signed [48:0]   p_ii_reg;
    logic signed [48:0]   p_ri_reg;
    logic signed [48:0]   p_ir_reg;
    logic signed [31:0]   a_re_reg;
    logic signed [31:0]   a_im_reg;
    logic signed [31:0]   pr_reg;
    logic signed [31:0]   pi_reg;
    logic [HW-1:0]        mag_idx_reg;
    logic [63:0]          sq_re_reg;
    logic [63:0]          sq_im_reg;
    logic [63:0]          best_mag_reg;
    logic [HW-1:0]        best_reg;

    logic [HW-1:0]        low_mask;
    logic [LOG2N-1:0]     addr_a;
    logic [LOG2N-1:0]     addr_b;
    logic [HW-1:0]        tw_idx;
    logic [LOG2N-1:0]     rd_a_addr;
    logic                 wr_en;
    logic [LOG2N-1:0]     wr_addr;
    logic [63:0]          wr_data;
    logic signed [49:0]   sum_r;
    logic signed [49:0]   sum_i;
    logic signed [49:0]   rnd_r;
    logic signed [49:0]   rnd_i;
    logic [63:0]          mag;
    logic [15:0]          peak_w;

    // butterfly addressing: a has a zero inserted at bit 'stage'
    assign low_mask = (HW'(1) << stage_reg) - HW'(1);
    assign addr_a   = {bf_reg & ~low_mask, 1'b0} | {1'b0, bf_reg & low_mask};
    assign addr_b   = addr_a | (LOG2N'(1) << stage_reg);
    assign tw_idx   = (bf_reg & low_mask) << (SW'(LOG2N - 1) - stage_reg);
    assign rd_a_addr = (state_reg == S_BF_RD) ? addr_a : {1'b0, mag_idx_reg};
    assign smp_rd_addr = ld_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            work_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= work_mem[rd_a_addr];
        rd_b_reg <= work_mem[addr_b];
        tw_reg   <= TW_ROM[tw_idx];
    end

    // product sums, rounded half up at scale 2^15
    assign sum_r = 50'(p_rr_reg) - 50'(p_ii_reg);
    assign sum_i = 50'(p_ri_reg) + 50'(p_ir_reg);
    assign rnd_r = (sum_r + 50'sd16384) >>> 15;
    assign rnd_i = (sum_i + 50'sd16384) >>> 15;
    assign mag   = sq_re_reg + sq_im_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_a;
        wr_data = {a_re_reg + pr_reg, a_im_reg + pi_reg};
        unique case (state_reg)
            S_LOAD, S_LOAD_END:
            begin
                wr_en   = ld_v_reg;
                wr_addr = bitrev(ld_idx_reg);
                wr_data = {ld_in_reg ? 32'(smp_rd_data) : 32'sd0, 32'd0};
            end
            S_BF_WA:
            begin
                wr_en = 1'b1;
            end
            S_BF_WB:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_b;
                wr_data = {a_re_reg - pr_reg, a_im_reg - pi_reg};
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign job_pop  = (state_reg == S_IDLE) && !job_empty;
    assign loaded   = (state_reg == S_LOAD_END);
    assign res_push = (state_reg == S_OUT) && !res_full;
    assign peak_w   = 16'(best_reg) - 16'(fbpb_pkg::PEAK_OFFSET);
    assign res_word.peak_bin       = peak_w[9:0];
    assign res_word.end_of_message = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ld_v_reg  <= 1'b0;
        end
        else
        begin
            ld_v_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!job_empty)
                    begin
                        count_reg  <= job_data[LOG2N:0];
                        last_reg   <= job_data[LOG2N+1];
                        ld_cnt_reg <= '0;
                        state_reg  <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    ld_v_reg   <= 1'b1;
                    ld_idx_reg <= ld_cnt_reg;
                    ld_in_reg  <= ({1'b0, ld_cnt_reg} < count_reg);
                    ld_cnt_reg <= ld_cnt_reg + 1'b1;
                    if (ld_cnt_reg == LOG2N'(N_POINTS - 1))
                    begin
                        state_reg <= S_LOAD_END;
                    end
                end
                S_LOAD_END:
                begin
                    bf_reg    <= '0;
                    stage_reg <= '0;
                    state_reg <= S_BF_RD;
                end
                S_BF_RD:
                begin
                    state_reg <= S_BF_MUL;
                end
                S_BF_MUL:
                begin
                    p_rr_reg  <= $signed(rd_b_reg[63:32]) * $signed(tw_reg[2*TWW-1:TWW]);
                    p_ii_reg  <= $signed(rd_b_reg[31:0]) * $signed(tw_reg[TWW-1:0]);
                    p_ri_reg  <= $signed(rd_b_reg[63:32]) * $signed(tw_reg[TWW-1:0]);
                    p_ir_reg  <= $signed(rd_b_reg[31:0]) * $signed(tw_reg[2*TWW-1:TWW]);
                    a_re_reg  <= rd_a_reg[63:32];
                    a_im_reg  <= rd_a_reg[31:0];
                    state_reg <= S_BF_SUM;
                end
                S_BF_SUM:
                begin
                    pr_reg    <= rnd_r[31:0];
                    pi_reg    <= rnd_i[31:0];
                    state_reg <= S_BF_WA;
                end
                S_BF_WA:
                begin
                    state_reg <= S_BF_WB;
                end
                S_BF_WB:
                begin
                    bf_reg    <= bf_reg + 1'b1;
                    state_reg <= S_BF_RD;
                    if (bf_reg == '1)
                    begin
                        stage_reg <= stage_reg + 1'b1;
                        if (stage_reg == SW'(LOG2N - 1))
                        begin
                            mag_idx_reg  <= '0;
                            best_reg     <= '0;
                            best_mag_reg <= '0;
                            state_reg    <= S_MAG_RD;
                        end
                    end
                end
                S_MAG_RD:
                begin
                    state_reg <= S_MAG_MUL;
                end
                S_MAG_MUL:
                begin
                    sq_re_reg <= $signed(rd_a_reg[63:32]) * $signed(rd_a_reg[63:32]);
                    sq_im_reg <= $signed(rd_a_reg[31:0]) * $signed(rd_a_reg[31:0]);
                    state_reg <= S_MAG_CMP;
                end
                S_MAG_CMP:
                begin
                    if (mag > best_mag_reg)
                    begin
                        best_mag_reg <= mag;
                        best_reg     <= mag_idx_reg;
                    end
                    mag_idx_reg <= mag_idx_reg + 1'b1;
                    state_reg   <= (mag_idx_reg == '1) ? S_OUT : S_MAG_RD;
                end
                S_OUT:
                begin
                    if (!res_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full) else $error("result pushed into full queue");
    a_loaded_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        loaded |=> !loaded) else $error("load release longer than one cycle");
    a_job_pop: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (state_reg == S_LOAD)) else $error("job taken without load");
    a_load_write: assert property (@(posedge clk) disable iff (!rst_n)
        ld_v_reg |-> (state_reg == S_LOAD || state_reg == S_LOAD_END))
        else $error("load write outside load phase");
`endif

endmodule

`default_nettype wire

>>> design/fft_block_peak_bin.sv
// ----------------------------------------------------------------------------
// fft_block_peak_bin: block FFT peak bin tone detector
// Collects audio samples into blocks, transforms them and reports the
// strongest bin of the lower half spectrum, less PEAK_OFFSET.
// ----------------------------------------------------------------------------
// Usage:
//   Sample words enter through push/full; a word is taken when push is high
//   and full is low. Result words leave through empty/pop; the oldest result
//   sits on 'result' while empty is low and is taken when pop is high.
//   batch_len is set through the APB port at byte address 0 (reset 256).
// Block flow:
//   A sample is taken while a block is open and full is low. When a block
//   closes (batch_len samples, clamped to 1..N_POINTS, or a word marked
//   last), intake holds until the engine has loaded it; the result follows
//   the butterfly passes and a magnitude scan of the lower N_POINTS/2 bins.
//   The transform time is set by the one shared butterfly unit on the
//   single write port of the work memory.
//   Intake of the next block runs while the transform is at work.
// Reset and stalls:
//   Reset empties both queues and the open block. A stalled receiver keeps
//   up to two results queued; beyond that the engine waits and intake
//   stops once a further block is closed.
// ----------------------------------------------------------------------------
`default_nettype none

module fft_block_peak_bin #(
    parameter int unsigned N_POINTS = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  wire logic                 push,
    input  wire fbpb_pkg::in_word_t   item,
    output logic                      full,
    input  wire logic                 pop,
    output fbpb_pkg::out_word_t       result,
    output logic                      empty
);

    localparam int unsigned LOG2N = $clog2(N_POINTS);
    localparam int unsigned JW    = LOG2N + 2;   // {last, count}
    localparam int unsigned RW    = $bits(fbpb_pkg::out_word_t);

    logic [fbpb_pkg::CFG_W-1:0] batch_len_reg;
    logic [LOG2N:0]             job_count;
    logic [JW-1:0]              job_in;
    logic [JW-1:0]              job_out;
    logic                       job_push;
    logic                       job_full;
    logic                       job_empty;
    logic                       job_pop;
    logic                       loaded;
    logic [LOG2N-1:0]           smp_rd_addr;
    logic signed [15:0]         smp_rd_data;
    logic                       res_push;
    logic                       res_full;
    fbpb_pkg::out_word_t        res_word;
    logic [RW-1:0]              res_q;

    // configuration port: register 0 at bytes 0 to 3 (paddr[2] low), bytes 4 to 7 read zero
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'(fbpb_pkg::CFG_BATCH_LEN)) ? 32'(batch_len_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_len_reg <= fbpb_pkg::BATCH_LEN_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2] == 1'(fbpb_pkg::CFG_BATCH_LEN))
        begin
            batch_len_reg <= pwdata[fbpb_pkg::CFG_W-1:0];
        end
    end

    fbpb_front #(
        .N_POINTS (N_POINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch_len   (batch_len_reg),
        .push        (push),
        .item        (item),
        .full        (full),
        .job_push    (job_push),
        .job_data    (job_count),
        .job_full    (job_full),
        .loaded      (loaded),
        .smp_rd_addr (smp_rd_addr),
        .smp_rd_data (smp_rd_data)
    );

    assign job_in = {item.last, job_count};

    // block jobs between intake and transform
    fbpb_fifo #(
        .WIDTH (JW)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .empty   (job_empty)
    );

    fbpb_back #(
        .N_POINTS (N_POINTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_data    (job_out),
        .job_empty   (job_empty),
        .job_pop     (job_pop),
        .loaded      (loaded),
        .smp_rd_addr (smp_rd_addr),
        .smp_rd_data (smp_rd_data),
        .res_push    (res_push),
        .res_word    (res_word),
        .res_full    (res_full)
    );

    // result words out to the receiver
    fbpb_fifo #(
        .WIDTH (RW)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_word),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_q),
        .empty   (empty)
    );

    assign result = res_q;

endmodule

`default_nettype wire
